[src/ibs_pkg.sv]
// types and constants shared by the box suppression block
`timescale 1ns / 1ps
`default_nettype none

package ibs_pkg;

	// reset value of the iou threshold, unsigned q0.16
	localparam logic [15:0] THR_RESET = 16'd29491;

	// one box as stored in the kept list
	typedef struct packed {
		logic [15:0] left;
		logic [15:0] top;
		logic [15:0] width;
		logic [15:0] height;
	} box_t;

	// one kept list entry: the box and its area
	typedef struct packed {
		box_t        box;
		logic [31:0] area;
	} entry_t;

	// status of the compare pipeline back to the sequencer
	typedef struct packed {
		logic vld;
		logic hit;
		logic busy;
	} cmp_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

[src/ibs_box_mem.sv]
// kept list memory: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module ibs_box_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire                          clk,
	input  wire                          wr_en,
	input  wire  [AW-1:0]                wr_addr,
	input  ibs_pkg::entry_t              wr_data,
	input  wire                          rd_en,
	input  wire  [AW-1:0]                rd_addr,
	output ibs_pkg::entry_t              rd_data
);
	import ibs_pkg::*;

	entry_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered output
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

[src/ibs_iou_unit.sv]
// pipelined iou test of the new box against one kept box per cycle
`timescale 1ns / 1ps
`default_nettype none

module ibs_iou_unit (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_vld,
	input  ibs_pkg::box_t    new_box,
	input  wire  [31:0]      new_area,
	input  wire  [15:0]      threshold,
	input  ibs_pkg::entry_t  kept,
	output ibs_pkg::cmp_t    status
);
	import ibs_pkg::*;

	logic        vld_s2, vld_s3, vld_s4, vld_s5;
	logic [15:0] ow_s2, oh_s2;
	logic [31:0] areab_s2, areab_s3;
	logic [31:0] inter_s3, inter_s4, inter_s5;
	logic [32:0] uni_s4;
	logic [48:0] prod_s5;

	logic [16:0] x_lo, x_ae, x_be, x_hi;
	logic [16:0] y_lo, y_ae, y_be, y_hi;
	logic [15:0] ow, oh;
	logic [32:0] uni;

	// overlap along each axis, edges formed at 17 bits
	always_comb begin
		x_lo = (new_box.left > kept.box.left) ? {1'b0, new_box.left} : {1'b0, kept.box.left};
		x_ae = {1'b0, new_box.left} + {1'b0, new_box.width};
		x_be = {1'b0, kept.box.left} + {1'b0, kept.box.width};
		x_hi = (x_ae < x_be) ? x_ae : x_be;
		ow   = (x_hi > x_lo) ? 16'(x_hi - x_lo) : 16'd0;
		y_lo = (new_box.top > kept.box.top) ? {1'b0, new_box.top} : {1'b0, kept.box.top};
		y_ae = {1'b0, new_box.top} + {1'b0, new_box.height};
		y_be = {1'b0, kept.box.top} + {1'b0, kept.box.height};
		y_hi = (y_ae < y_be) ? y_ae : y_be;
		oh   = (y_hi > y_lo) ? 16'(y_hi - y_lo) : 16'd0;
	end

	// union never goes below zero since inter fits in either area
	assign uni = {1'b0, new_area} + {1'b0, areab_s3} - {1'b0, inter_s3};

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s2 <= in_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// datapath stages: overlap, intersection, union, threshold product
	always_ff @(posedge clk) begin
		ow_s2    <= ow;
		oh_s2    <= oh;
		areab_s2 <= kept.area;
		inter_s3 <= ow_s2 * oh_s2;
		areab_s3 <= areab_s2;
		uni_s4   <= uni;
		inter_s4 <= inter_s3;
		prod_s5  <= threshold * uni_s4;
		inter_s5 <= inter_s4;
	end

	// suppress when inter * 65536 > threshold * union
	always_comb begin
		status.vld  = vld_s5;
		status.hit  = {1'b0, inter_s5, 16'h0000} > prod_s5;
		status.busy = vld_s2 | vld_s3 | vld_s4 | vld_s5;
	end

endmodule

`default_nettype wire

[src/iou_box_suppression.sv]
// top level of the greedy iou box suppression block
// Boxes come in on the input channel (in_valid / in_stall), one word per box,
// already sorted by falling score. frame_start on a word empties the kept
// list and restarts box numbering before that box is handled.
// Each box is read against every kept box of the frame, one kept-list memory
// read per cycle, followed by a four stage compare pipeline. The block works
// on one box at a time, so the memory scan plus the pipeline drain set the
// pace, and the next box is taken once the result of the last one is formed.
// One result word per box leaves on the output channel (out_valid /
// out_stall) from an output register; the next box is accepted while that
// word still waits. A stalled result holds its value; a box that finishes
// while the previous result is still stalled waits until it is taken.
// The threshold is written through cfg_wr_en / cfg_wr_data; the user is to
// write it only while idle, and the block itself does not enforce this.
// After reset the kept list is empty, numbering starts at zero and the
// threshold is 29491 (about 0.45). The memory needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module iou_box_suppression #(
	parameter int MAX_KEPT = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_wr_en,
	input  wire  [15:0] cfg_wr_data,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         frame_start,
	input  wire  [15:0] box_left,
	input  wire  [15:0] box_top,
	input  wire  [15:0] box_width,
	input  wire  [15:0] box_height,
	output logic        out_valid,
	input  wire         out_stall,
	output logic        keep,
	output logic [15:0] box_index,
	output logic [6:0]  kept_count,
	output logic        overflow
);
	import ibs_pkg::*;

	localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int CW = $clog2(MAX_KEPT + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_KEPT);

	state_t        state_q, state_d;
	logic [15:0]   thr_q;
	logic [CW-1:0] total_q;
	logic [CW-1:0] rd_cnt_q;
	logic [15:0]   pos_q;
	logic [15:0]   idx_q;
	logic          supp_q;
	logic          rd_vld_s1;
	box_t          nb_q;
	logic [31:0]   area_q;
	logic          out_valid_q;
	logic          keep_q, ovf_q;
	logic [15:0]   box_index_q;
	logic [6:0]    kept_count_q;

	logic          accept;
	logic          issue;
	logic          scan_end;
	logic          finish;
	logic          out_free;
	logic          room;
	logic          wr_en;
	logic [15:0]   idx_new;
	entry_t        wr_data;
	entry_t        rd_data;
	cmp_t          cmp;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign issue    = (state_q == ST_SCAN) && (rd_cnt_q < total_q);
	assign scan_end = (rd_cnt_q == total_q) && !rd_vld_s1 && !cmp.busy;
	assign finish   = (state_q == ST_DONE) && out_free;
	assign room     = total_q < MAX_CNT;
	assign wr_en    = finish && !supp_q && room;
	assign idx_new  = frame_start ? 16'd0 : pos_q;

	// sequencer next state and input stall
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_end) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers: threshold, counters, suppress flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= THR_RESET;
			total_q   <= '0;
			rd_cnt_q  <= '0;
			pos_q     <= 16'd0;
			supp_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (cfg_wr_en) thr_q <= cfg_wr_data;
			if (accept) begin
				pos_q    <= idx_new + 16'd1;
				rd_cnt_q <= '0;
				supp_q   <= 1'b0;
				if (frame_start) total_q <= '0;
			end else begin
				if (issue) rd_cnt_q <= rd_cnt_q + 1'b1;
				if (cmp.vld && cmp.hit) supp_q <= 1'b1;
				if (wr_en) total_q <= total_q + 1'b1;
			end
		end
	end

	// new box held for the whole scan
	always_ff @(posedge clk) begin
		if (accept) begin
			nb_q.left   <= box_left;
			nb_q.top    <= box_top;
			nb_q.width  <= box_width;
			nb_q.height <= box_height;
			area_q      <= box_width * box_height;
			idx_q       <= idx_new;
		end
	end

	// entry appended at the end of the list
	assign wr_data.box  = nb_q;
	assign wr_data.area = area_q;

	ibs_box_mem #(
		.DEPTH (MAX_KEPT),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (total_q[AW-1:0]),
		.wr_data (wr_data),
		.rd_en   (issue),
		.rd_addr (rd_cnt_q[AW-1:0]),
		.rd_data (rd_data)
	);

	ibs_iou_unit u_iou (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (rd_vld_s1),
		.new_box   (nb_q),
		.new_area  (area_q),
		.threshold (thr_q),
		.kept      (rd_data),
		.status    (cmp)
	);

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (finish) begin
			keep_q       <= !supp_q && room;
			ovf_q        <= !supp_q && !room;
			box_index_q  <= idx_q;
			kept_count_q <= 7'(wr_en ? total_q + 1'b1 : total_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign keep       = keep_q;
	assign overflow   = ovf_q;
	assign box_index  = box_index_q;
	assign kept_count = kept_count_q;

endmodule

`default_nettype wire

[src/ibs_checker.sv]
// port level checks of the box suppression block and their bind
`timescale 1ns / 1ps
`default_nettype none

module ibs_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire        out_valid,
	input wire        out_stall,
	input wire        keep,
	input wire [15:0] box_index,
	input wire [6:0]  kept_count,
	input wire        overflow
);

	// a stalled result word stays valid
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	// a stalled result word holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable({keep, box_index, kept_count, overflow}))
		else $error("result payload changed while stalled");

	// a box is never both kept and flagged as overflow
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(keep && overflow))
		else $error("keep and overflow both set");

	// one box at a time: input stalls right after a box is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second box taken during a scan");

endmodule

bind iou_box_suppression ibs_checker u_ibs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.keep       (keep),
	.box_index  (box_index),
	.kept_count (kept_count),
	.overflow   (overflow)
);

`default_nettype wire

[verif/tb.sv]
// self-checking testbench for the greedy iou box suppression block
`timescale 1ns / 1ps

module tb;

	import ibs_pkg::*;

	localparam int MAX_KEPT       = 64;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 600;
	localparam int MAX_SHOWN      = 10;

	// one input word: frame flag plus box
	typedef struct packed {
		logic frame_start;
		box_t box;
	} box_word_t;

	// one result word
	typedef struct packed {
		logic        keep;
		logic [15:0] box_index;
		logic [6:0]  kept_count;
		logic        overflow;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        frame_start = 1'b0;
	logic [15:0] box_left = '0;
	logic [15:0] box_top = '0;
	logic [15:0] box_width = '0;
	logic [15:0] box_height = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        keep;
	logic [15:0] box_index;
	logic [6:0]  kept_count;
	logic        overflow;

	iou_box_suppression #(
		.MAX_KEPT(MAX_KEPT)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.frame_start(frame_start),
		.box_left   (box_left),
		.box_top    (box_top),
		.box_width  (box_width),
		.box_height (box_height),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.keep       (keep),
		.box_index  (box_index),
		.kept_count (kept_count),
		.overflow   (overflow)
	);

	// predictor state
	box_t        kept_list [MAX_KEPT];
	logic [31:0] kept_area [MAX_KEPT];
	int          kept_n = 0;
	logic [15:0] next_index = '0;
	logic [15:0] iou_thr = THR_RESET;

	box_word_t   box_queue [$];
	verdict_t    verdict_q [$];
	box_word_t   offered;
	verdict_t    got_v, want_v;
	int          queued_count = 0;
	int          taken_count = 0;
	int          mismatches = 0;
	int          idle_cycles = 0;
	int          send_idle = 0;
	int          recv_idle = 0;
	logic        hold_go = 1'b0;
	int          hold_left = 0;

	// cluster centers of the current random frame
	int anchor_x [4], anchor_y [4], span_w [4], span_h [4];

	// clock
	initial begin
		forever #10 clk = ~clk;
	end

	// overlap of two spans, ends formed at 17 bits
	function automatic logic [16:0] axis_overlap(logic [15:0] a0, logic [15:0] alen,
			logic [15:0] b0, logic [15:0] blen);
		logic [16:0] lo, ae, be, hi;
		lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
		ae = {1'b0, a0} + {1'b0, alen};
		be = {1'b0, b0} + {1'b0, blen};
		hi = (ae < be) ? ae : be;
		return (hi > lo) ? hi - lo : 17'd0;
	endfunction

	// expected verdict for one accepted box, updates the kept list
	function automatic verdict_t nms_verdict(box_word_t w);
		verdict_t    v;
		logic [31:0] area;
		logic [63:0] inter, uni;
		logic        survive;
		int          j;
		if (w.frame_start) begin
			kept_n = 0;
			next_index = '0;
		end
		area = 32'(w.box.width) * 32'(w.box.height);
		v.box_index = next_index;
		next_index = next_index + 16'd1;
		survive = 1'b1;
		for (j = 0; j < kept_n; j++) begin
			inter = 64'(axis_overlap(w.box.left, w.box.width,
				kept_list[j].left, kept_list[j].width))
				* 64'(axis_overlap(w.box.top, w.box.height,
				kept_list[j].top, kept_list[j].height));
			uni = 64'(area) + 64'(kept_area[j]) - inter;
			if ((inter << 16) > 64'(iou_thr) * uni)
				survive = 1'b0;
		end
		v.keep = 1'b0;
		v.overflow = 1'b0;
		if (survive) begin
			if (kept_n < MAX_KEPT) begin
				kept_list[kept_n] = w.box;
				kept_area[kept_n] = area;
				kept_n++;
				v.keep = 1'b1;
			end else begin
				v.overflow = 1'b1;
			end
		end
		v.kept_count = 7'(kept_n);
		return v;
	endfunction

	function automatic box_word_t box_word(logic fs, logic [15:0] l, logic [15:0] t,
			logic [15:0] w, logic [15:0] h);
		box_word_t b;
		b.frame_start = fs;
		b.box = '{left: l, top: t, width: w, height: h};
		return b;
	endfunction

	function automatic logic [15:0] jitter(int base, int spread);
		return 16'(base + int'($urandom_range(2 * spread)) - spread);
	endfunction

	// pick one of the edge values or a random one
	function automatic logic [15:0] edge_value();
		case ($urandom_range(3))
			0: return 16'h0000;
			1: return 16'hffff;
			2: return 16'h0001;
			default: return 16'($urandom);
		endcase
	endfunction

	// random box: mostly near a cluster center so iou lands near the threshold
	function automatic box_word_t random_box(logic fs);
		box_word_t b;
		int        pick, k;
		pick = $urandom_range(99);
		k = $urandom_range(3);
		b.frame_start = fs;
		if (pick < 55) begin
			b.box.left   = jitter(anchor_x[k], span_w[k] / 4 + 1);
			b.box.top    = jitter(anchor_y[k], span_h[k] / 4 + 1);
			b.box.width  = jitter(span_w[k], span_w[k] / 8 + 1);
			b.box.height = jitter(span_h[k], span_h[k] / 8 + 1);
		end else if (pick < 80) begin
			b.box.left   = 16'($urandom);
			b.box.top    = 16'($urandom);
			b.box.width  = 16'($urandom_range(16, 2048));
			b.box.height = 16'($urandom_range(16, 2048));
		end else if (pick < 92) begin
			b.box.left   = 16'($urandom);
			b.box.top    = 16'($urandom);
			b.box.width  = 16'($urandom);
			b.box.height = 16'($urandom);
		end else begin
			b.box.left   = edge_value();
			b.box.top    = edge_value();
			b.box.width  = edge_value();
			b.box.height = edge_value();
		end
		return b;
	endfunction

	task automatic push_word(box_word_t w);
		box_queue.insert(box_queue.size(), w);
		queued_count++;
	endtask

	// random frames of random length, a few long enough to fill the list
	task automatic queue_frames(int n);
		int k, i, left_in_frame;
		left_in_frame = 0;
		for (k = 0; k < n; k++) begin
			if (left_in_frame == 0) begin
				for (i = 0; i < 4; i++) begin
					anchor_x[i] = $urandom_range(60000);
					anchor_y[i] = $urandom_range(60000);
					span_w[i] = $urandom_range(64, 4096);
					span_h[i] = $urandom_range(64, 4096);
				end
				left_in_frame = ($urandom_range(7) == 0) ? $urandom_range(66, 90)
					: $urandom_range(1, 40);
				push_word(random_box(1'b1));
			end else begin
				push_word(random_box(1'b0));
			end
			left_in_frame--;
		end
	endtask

	// wait until every word is taken and every verdict has arrived
	task automatic drain();
		while (taken_count != queued_count || verdict_q.size() != 0)
			@(posedge clk);
		repeat (MAX_KEPT + 10) @(posedge clk);
	endtask

	task automatic write_threshold(logic [15:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		iou_thr = v;
	endtask

	task automatic set_idling(int s, int r);
		send_idle <= s;
		recv_idle <= r;
	endtask

	task automatic flag_error(string msg);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("%0t: %s", $realtime, msg);
	endtask

	// driver: offer the next word once the current one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				verdict_q.insert(verdict_q.size(), nms_verdict(offered));
				taken_count++;
			end
			if (!in_valid || !in_stall) begin
				if (box_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
					offered = box_queue.pop_front();
					in_valid    <= 1'b1;
					frame_start <= offered.frame_start;
					box_left    <= offered.box.left;
					box_top     <= offered.box.top;
					box_width   <= offered.box.width;
					box_height  <= offered.box.height;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall, with an optional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
		end else begin
			if (hold_go)
				hold_left <= HOLD_CYCLES;
			else if (hold_left != 0)
				hold_left <= hold_left - 1;
			out_stall <= hold_go || hold_left > 1 || ($urandom_range(99) < recv_idle);
		end
	end

	// monitor: compare each taken result word with the oldest verdict
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_v = '{keep: keep, box_index: box_index, kept_count: kept_count,
				overflow: overflow};
			if (verdict_q.size() == 0) begin
				flag_error($sformatf("result word with none expected: keep %0d index %0d count %0d ovf %0d",
					got_v.keep, got_v.box_index, got_v.kept_count, got_v.overflow));
			end else begin
				want_v = verdict_q.pop_front();
				if (got_v !== want_v)
					flag_error($sformatf(
						"mismatch: keep %0d/%0d index %0d/%0d count %0d/%0d ovf %0d/%0d (exp/act)",
						want_v.keep, got_v.keep, want_v.box_index, got_v.box_index,
						want_v.kept_count, got_v.kept_count, want_v.overflow, got_v.overflow));
			end
		end
	end

	// watchdog on cycles with no word moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("iou_box_suppression regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// stimulus sequence
	initial begin
		int k;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed boxes at the reset threshold
		set_idling(0, 0);
		push_word(box_word(1'b1, 16'd0, 16'd0, 16'd0, 16'd0));
		// zero union with the first box: kept
		push_word(box_word(1'b0, 16'd0, 16'd0, 16'd0, 16'd0));
		push_word(box_word(1'b0, 16'd100, 16'd100, 16'd160, 16'd160));
		push_word(box_word(1'b0, 16'd100, 16'd100, 16'd160, 16'd160));
		// touches the right edge only: no overlap
		push_word(box_word(1'b0, 16'd260, 16'd100, 16'd160, 16'd160));
		// far corner, edges past 16 bits
		push_word(box_word(1'b0, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
		push_word(box_word(1'b0, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
		push_word(box_word(1'b0, 16'hfffe, 16'hffff, 16'hffff, 16'hffff));
		push_word(box_word(1'b0, 16'd0, 16'd0, 16'hffff, 16'hffff));
		push_word(box_word(1'b0, 16'd180, 16'd100, 16'd160, 16'd160));
		push_word(box_word(1'b0, 16'd120, 16'd100, 16'd160, 16'd160));
		drain();

		// iou exactly at one half is not suppressed
		write_threshold(16'd32768);
		push_word(box_word(1'b1, 16'd1000, 16'd0, 16'd30, 16'd10));
		push_word(box_word(1'b0, 16'd1010, 16'd0, 16'd30, 16'd10));
		push_word(box_word(1'b0, 16'd1005, 16'd0, 16'd30, 16'd10));
		push_word(box_word(1'b0, 16'd5, 16'd5, 16'd0, 16'd100));
		push_word(box_word(1'b1, 16'd1005, 16'd0, 16'd30, 16'd10));
		drain();

		// any overlap suppresses
		write_threshold(16'd0);
		set_idling(48, 0);
		queue_frames(330);
		drain();

		// fill the list, then two more survivors and one suppressed box
		write_threshold(16'hffff);
		set_idling(0, 48);
		for (k = 0; k < MAX_KEPT + 2; k++)
			push_word(box_word(k == 0, 16'(k * 512), 16'd0, 16'd16, 16'd16));
		push_word(box_word(1'b0, 16'd0, 16'd0, 16'd16, 16'd16));
		queue_frames(330);
		drain();

		// long receiver hold-off while words keep coming
		write_threshold(16'($urandom));
		set_idling(9, 9);
		queue_frames(330);
		repeat (40) @(posedge clk);
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		drain();

		write_threshold(THR_RESET);
		set_idling(0, 0);
		queue_frames(330);
		drain();

		write_threshold(16'($urandom));
		set_idling(48, 0);
		queue_frames(330);
		drain();

		if (verdict_q.size() != 0)
			flag_error("verdicts left over at the end");
		if (mismatches == 0)
			$display("iou_box_suppression regression: pass");
		else
			$display("iou_box_suppression regression: fail");
		$finish;
	end

endmodule
